>>> src/bsgs_pkg.sv
// Shared types, constants and codes of the Black-Scholes grid stencil.
package bsgs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int WIDE_W        = 63;
    localparam int MUL_A_W       = 33;
    localparam int MUL_B_W       = 34;
    localparam int PROD_W        = MUL_A_W + MUL_B_W;
    localparam int FULL_W        = PROD_W + 33;
    localparam int SUM_W         = WIDE_W + 2;

    localparam logic signed [WIDE_W-1:0] WIDE_LIMIT     = 63'sh2000_0000_0000_0000;
    localparam logic signed [WIDE_W-1:0] WIDE_LIMIT_NEG = -WIDE_LIMIT;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] spot;
        logic               active;
        logic               last_point;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] point_value;
        logic signed [31:0] delta;
        logic signed [31:0] gamma;
        logic signed [31:0] drift;
        logic signed [31:0] theta;
        logic               last_result;
    } t_out_item;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_SIGMA_SQ,
        CFG_RISKFREE_RATE,
        CFG_DIVIDEND_YIELD,
        CFG_INV_TWO_STEP,
        CFG_INV_STEP_SQ,
        CFG_LOWER_BOUNDARY,
        CFG_UPPER_BOUNDARY
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_DELTA,
        OP_GAMMA,
        OP_T1,
        OP_C1,
        OP_DISC,
        OP_T2_LO,
        OP_T2_HI,
        OP_CONV_LO,
        OP_CONV_HI,
        OP_DIFF_LO,
        OP_DIFF_HI
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic load_center;
        logic issue;
        t_op  op;
        logic use_upper;
        logic left_older;
        logic load_out;
        logic out_last;
        logic shift_window;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

>>> src/bsgs_ctrl.sv
// Sequencer of the grid stencil: window fill state and the product schedule.
module bsgs_ctrl import bsgs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_filled, n_filled;
    t_op        r_op, n_op;
    logic       r_use_upper, n_use_upper;
    logic       r_left_older, n_left_older;
    logic       r_pend, n_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_filled     <= 2'd0;
            r_op         <= OP_DELTA;
            r_use_upper  <= 1'b0;
            r_left_older <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_filled     <= n_filled;
            r_op         <= n_op;
            r_use_upper  <= n_use_upper;
            r_left_older <= n_left_older;
            r_pend       <= n_pend;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_filled     = r_filled;
        n_op         = r_op;
        n_use_upper  = r_use_upper;
        n_left_older = r_left_older;
        n_pend       = r_pend;
        o_in_ready   = 1'b0;
        o_cmd              = '0;
        o_cmd.op           = r_op;
        o_cmd.use_upper    = r_use_upper;
        o_cmd.left_older   = r_left_older;
        o_cmd.out_last     = r_use_upper;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_filled == 2'd0) begin
                        o_cmd.load_center = 1'b1;
                        if (i_in_last) begin
                            n_state      = ST_CALC;
                            n_op         = OP_DELTA;
                            n_use_upper  = 1'b1;
                            n_left_older = 1'b0;
                            n_pend       = 1'b0;
                            n_filled     = 2'd0;
                        end else begin
                            n_filled = 2'd1;
                        end
                    end else begin
                        o_cmd.latch_in = 1'b1;
                        n_state        = ST_CALC;
                        n_op           = OP_DELTA;
                        n_use_upper    = 1'b0;
                        n_left_older   = (r_filled == 2'd2);
                        n_pend         = i_in_last;
                    end
                end
            end
            ST_CALC: begin
                o_cmd.issue = 1'b1;
                if (r_op == OP_DIFF_HI) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_op = t_op'(4'(r_op) + 4'd1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (!r_use_upper) begin
                        o_cmd.shift_window = 1'b1;
                        if (r_pend) begin
                            n_state      = ST_CALC;
                            n_op         = OP_DELTA;
                            n_use_upper  = 1'b1;
                            n_left_older = 1'b1;
                            n_pend       = 1'b0;
                            n_filled     = 2'd0;
                        end else begin
                            n_state  = ST_IDLE;
                            n_filled = 2'd2;
                        end
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled != 2'd3)
        else $error("window fill count out of range");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("result loaded over a held item");

    a_pend_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_out && !r_use_upper && r_pend) |=>
            (r_state == ST_CALC && r_use_upper && r_left_older && r_filled == 2'd0))
        else $error("second result of the last point not started");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_out && r_use_upper) |=> (r_state == ST_IDLE && r_filled == 2'd0))
        else $error("window not empty after the final point");
`endif

endmodule

>>> src/bsgs_datapath.sv
// Datapath of the grid stencil: registers, window, shared multiplier and result.
module bsgs_datapath import bsgs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  t_in_item             i_in_item,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output t_out_item            o_out_item
);

    localparam logic signed [31:0] SAT_HI = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_LO = 32'sh8000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] res;
        if (v > SUM_W'(SAT_HI)) begin
            res = SAT_HI;
        end else if (v < SUM_W'(SAT_LO)) begin
            res = SAT_LO;
        end else begin
            res = 32'(v);
        end
        return res;
    endfunction

    logic        [30:0] r_hss;
    logic signed [31:0] r_rate;
    logic signed [31:0] r_yield;
    logic        [30:0] r_inv2;
    logic        [30:0] r_invsq;
    logic signed [31:0] r_lower;
    logic signed [31:0] r_upper;

    logic signed [31:0] r_older;
    logic signed [31:0] r_center_value;
    logic signed [31:0] r_center_spot;
    logic               r_center_active;
    logic signed [31:0] r_in_value;
    logic signed [31:0] r_in_spot;
    logic               r_in_active;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc_lo;
    logic                     r_wb_valid;
    t_op                      r_wb_op;

    logic signed [31:0]       r_delta;
    logic signed [31:0]       r_gamma;
    logic signed [WIDE_W-1:0] r_t1;
    logic signed [WIDE_W-1:0] r_c1;
    logic signed [WIDE_W-1:0] r_disc;
    logic signed [WIDE_W-1:0] r_t2;
    logic signed [WIDE_W-1:0] r_conv;
    logic signed [WIDE_W-1:0] r_diff;

    logic               r_out_valid;
    t_out_item          r_out;

    logic signed [31:0]        right_v;
    logic signed [31:0]        left_v;
    logic signed [32:0]        d1;
    logic signed [33:0]        d2;
    logic signed [32:0]        rq;
    logic signed [MUL_A_W-1:0] a_mul;
    logic signed [MUL_B_W-1:0] b_mul;
    logic signed [PROD_W-1:0]  prod_c;
    logic                      wb_hi;
    logic signed [FULL_W-1:0]  full;
    logic signed [FULL_W-1:0]  shifted;
    logic signed [WIDE_W-1:0]  clamped;
    logic signed [SUM_W-1:0]   op_sum;
    logic signed [31:0]        op_sat;
    logic signed [31:0]        drift;
    logic signed [31:0]        theta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hss   <= 31'd0;
            r_rate  <= 32'sd0;
            r_yield <= 32'sd0;
            r_inv2  <= 31'(1 << (FRAC_BITS - 1));
            r_invsq <= 31'(1 << FRAC_BITS);
            r_lower <= 32'sd0;
            r_upper <= 32'sd0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HALF_SIGMA_SQ:  r_hss   <= i_cfg_data[30:0];
                CFG_RISKFREE_RATE:  r_rate  <= i_cfg_data;
                CFG_DIVIDEND_YIELD: r_yield <= i_cfg_data;
                CFG_INV_TWO_STEP:   r_inv2  <= i_cfg_data[30:0];
                CFG_INV_STEP_SQ:    r_invsq <= i_cfg_data[30:0];
                CFG_LOWER_BOUNDARY: r_lower <= i_cfg_data;
                CFG_UPPER_BOUNDARY: r_upper <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older         <= 32'sd0;
            r_center_value  <= 32'sd0;
            r_center_spot   <= 32'sd0;
            r_center_active <= 1'b0;
        end else if (i_cmd.load_center) begin
            r_center_value  <= i_in_item.value;
            r_center_spot   <= i_in_item.spot;
            r_center_active <= i_in_item.active;
        end else if (i_cmd.shift_window) begin
            r_older         <= r_center_value;
            r_center_value  <= r_in_value;
            r_center_spot   <= r_in_spot;
            r_center_active <= r_in_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in_value  <= i_in_item.value;
            r_in_spot   <= i_in_item.spot;
            r_in_active <= i_in_item.active;
        end
    end

    always_comb begin
        right_v = i_cmd.use_upper ? r_upper : r_in_value;
        left_v  = i_cmd.left_older ? r_older : r_lower;
        d1      = 33'(right_v) - 33'(left_v);
        d2      = 34'(right_v) + 34'(left_v) - (34'(r_center_value) <<< 1);
        rq      = 33'(r_rate) - 33'(r_yield);
    end

    always_comb begin
        a_mul = '0;
        b_mul = '0;
        case (i_cmd.op)
            OP_DELTA: begin
                a_mul = {2'b00, r_inv2};
                b_mul = 34'(d1);
            end
            OP_GAMMA: begin
                a_mul = {2'b00, r_invsq};
                b_mul = d2;
            end
            OP_T1: begin
                a_mul = 33'(r_center_spot);
                b_mul = {3'b000, r_hss};
            end
            OP_C1: begin
                a_mul = 33'(r_center_spot);
                b_mul = 34'(rq);
            end
            OP_DISC: begin
                a_mul = 33'(r_center_value);
                b_mul = 34'(r_rate);
            end
            OP_T2_LO: begin
                a_mul = {1'b0, r_t1[31:0]};
                b_mul = 34'(r_center_spot);
            end
            OP_T2_HI: begin
                a_mul = 33'($signed(r_t1[WIDE_W-1:32]));
                b_mul = 34'(r_center_spot);
            end
            OP_CONV_LO: begin
                a_mul = {1'b0, r_c1[31:0]};
                b_mul = 34'(r_delta);
            end
            OP_CONV_HI: begin
                a_mul = 33'($signed(r_c1[WIDE_W-1:32]));
                b_mul = 34'(r_delta);
            end
            OP_DIFF_LO: begin
                a_mul = {1'b0, r_t2[31:0]};
                b_mul = 34'(r_gamma);
            end
            OP_DIFF_HI: begin
                a_mul = 33'($signed(r_t2[WIDE_W-1:32]));
                b_mul = 34'(r_gamma);
            end
            default: begin
                a_mul = '0;
                b_mul = '0;
            end
        endcase
    end

    assign prod_c = a_mul * b_mul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
        end else begin
            r_wb_valid <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_prod  <= prod_c;
            r_wb_op <= i_cmd.op;
        end
    end

    always_comb begin
        wb_hi   = (r_wb_op == OP_T2_HI) || (r_wb_op == OP_CONV_HI) || (r_wb_op == OP_DIFF_HI);
        full    = wb_hi ? (FULL_W'(r_acc_lo) + (FULL_W'(r_prod) <<< 32)) : FULL_W'(r_prod);
        shifted = full >>> FRAC_BITS;
        if (shifted > FULL_W'(WIDE_LIMIT)) begin
            clamped = WIDE_LIMIT;
        end else if (shifted < FULL_W'(WIDE_LIMIT_NEG)) begin
            clamped = WIDE_LIMIT_NEG;
        end else begin
            clamped = WIDE_W'(shifted);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_wb_valid) begin
            case (r_wb_op)
                OP_DELTA:   r_delta  <= sat32(SUM_W'(clamped));
                OP_GAMMA:   r_gamma  <= sat32(SUM_W'(clamped));
                OP_T1:      r_t1     <= clamped;
                OP_C1:      r_c1     <= clamped;
                OP_DISC:    r_disc   <= clamped;
                OP_T2_LO:   r_acc_lo <= r_prod;
                OP_T2_HI:   r_t2     <= clamped;
                OP_CONV_LO: r_acc_lo <= r_prod;
                OP_CONV_HI: r_conv   <= clamped;
                OP_DIFF_LO: r_acc_lo <= r_prod;
                OP_DIFF_HI: r_diff   <= clamped;
                default: ;
            endcase
        end
    end

    always_comb begin
        op_sum = SUM_W'(r_diff) + SUM_W'(r_conv) - SUM_W'(r_disc);
        op_sat = sat32(op_sum);
        drift  = r_center_active ? op_sat : 32'sd0;
        theta  = sat32(-SUM_W'(drift));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.point_value <= r_center_value;
            r_out.delta       <= r_delta;
            r_out.gamma       <= r_gamma;
            r_out.drift       <= drift;
            r_out.theta       <= theta;
            r_out.last_result <= i_cmd.out_last;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out;

endmodule

>>> src/black_scholes_grid_stencil.sv
// Top level of the Black-Scholes three-point grid stencil.
// Grid points enter on the input channel (i_in_valid / o_in_ready) in
// ascending price order, the highest point of a sweep marked by last_point.
// Each result leaves on the output channel (o_out_valid / i_out_ready) one
// point late: value, delta, gamma, drift and theta of the centre point.
// The marked last point gives two results, the second with last_result set.
// Registers are written on the configuration channel (i_cfg_valid,
// o_cfg_ready always high, i_cfg_index, i_cfg_data); indexes beyond the
// list are ignored. Write them only while the block is idle.
// Each result passes from the accepted point to the output register in
// steps: one shared 33x34 multiplier runs eleven passes (wide operands
// in two halves), then a drain state empties the pipeline and a done state
// loads the output. A point that only fills the window is just stored; the
// last point gives two results back to back.
// The next point is accepted while a finished item still waits on the
// output; a stalled receiver holds the pipeline in its final cycle.
// Synchronous reset empties the window, clears the output and restores
// the register defaults.
module black_scholes_grid_stencil import bsgs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    bsgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_item.last_point),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bsgs_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
